// File: rtl/hmrc_pkg.sv
// Shared types and constants for the monitor reading converter.
`default_nettype none

package hmrc_pkg;

    // Field widths
    localparam int CMD_W       = 4;
    localparam int RAW_W       = 8;
    localparam int VALUE_W     = 22;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int GAIN_W      = 13;
    localparam int OFFS_W      = 24;
    localparam int DIRECT_W    = 18;

    // Channel codes
    localparam logic [CMD_W-1:0] CMD_CORE0       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CORE1       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_3V3         = 4'd2;
    localparam logic [CMD_W-1:0] CMD_P5          = 4'd3;
    localparam logic [CMD_W-1:0] CMD_P12         = 4'd4;
    localparam logic [CMD_W-1:0] CMD_N12         = 4'd5;
    localparam logic [CMD_W-1:0] CMD_N5          = 4'd6;
    localparam logic [CMD_W-1:0] CMD_TEMP_LOCAL  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_TEMP_R1     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_TEMP_R2     = 4'd9;
    localparam logic [CMD_W-1:0] CMD_FAN1        = 4'd10;
    localparam logic [CMD_W-1:0] CMD_FAN2        = 4'd11;
    localparam logic [CMD_W-1:0] CMD_FAN3        = 4'd12;

    // Chip families
    localparam logic [1:0] CHIP_A = 2'd0;
    localparam logic [1:0] CHIP_B = 2'd1;
    localparam logic [1:0] CHIP_C = 2'd2;
    localparam logic [1:0] CHIP_D = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CHIP_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN1_DIV  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAN2_DIV  = 2'd2;

    // Voltage gains in thousandths
    localparam logic [GAIN_W-1:0] GAIN_UNIT    = 13'd1000;
    localparam logic [GAIN_W-1:0] GAIN_P5      = 13'd1680;
    localparam logic [GAIN_W-1:0] GAIN_4V00    = 13'd4000;
    localparam logic [GAIN_W-1:0] GAIN_3V80    = 13'd3800;
    localparam logic [GAIN_W-1:0] GAIN_3V47    = 13'd3470;
    localparam logic [GAIN_W-1:0] GAIN_1V667   = 13'd1667;
    localparam logic [GAIN_W-1:0] GAIN_1V50    = 13'd1500;
    localparam logic [GAIN_W-1:0] GAIN_D_N12   = 13'd5143;
    localparam logic [GAIN_W-1:0] GAIN_D_N5    = 13'd3143;

    // Family D offsets, in millivolts times one thousand
    localparam logic [OFFS_W-1:0] OFFS_NONE    = 24'd0;
    localparam logic [OFFS_W-1:0] OFFS_D_N12   = 24'd14914000;
    localparam logic [OFFS_W-1:0] OFFS_D_N5    = 24'd7714000;

    // Temperature and fan limits
    localparam logic [DIRECT_W-1:0] TEMP_SCALE = 18'd1000;
    localparam logic [DIRECT_W-1:0] TEMP_HALF  = 18'd500;
    localparam logic [RAW_W-1:0]    REMOTE_MAX = 8'd200;
    localparam logic [RAW_W-1:0]    FRAC_HALF  = 8'd128;
    localparam logic [RAW_W-1:0]    FAN_STUCK  = 8'd255;
    localparam logic [RAW_W-1:0]    FAN_NONE   = 8'd0;
    localparam logic [1:0]          FAN3_SHIFT = 2'd1;

    // Voltage rounding: divide by 1000 as multiply by ceil(2^35/1000), shift by 35
    localparam int                  PROD_W      = 25;
    localparam int                  RECIP_W     = 26;
    localparam int                  RECIP_SHIFT = 35;
    localparam int                  VOLT_Q_W    = 15;
    localparam logic [PROD_W-1:0]   ROUND_HALF  = 25'd500;
    localparam logic [RECIP_W-1:0]  RECIP_K     = 26'd34359739;

    // Fan divider: fixed dividend, a few quotient bits per stage
    localparam int                  DIV_W       = 21;
    localparam logic [DIV_W-1:0]    FAN_CONST   = 21'd1350000;
    localparam int                  DIV_BPS     = 3;
    localparam int                  DIV_STAGES  = DIV_W / DIV_BPS;

    // Queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [1:0] {
        KIND_VOLT,
        KIND_FAN,
        KIND_DIRECT
    } kind_t;

    // Classified item handed from front to back
    typedef struct packed {
        kind_t                 kind;
        logic                  absent;
        logic [RAW_W-1:0]      raw;
        logic [GAIN_W-1:0]     gain;
        logic [OFFS_W-1:0]     offset;
        logic                  negate;
        logic [1:0]            shift;
        logic [DIRECT_W-1:0]   direct;
    } op_t;

    // Fields carried alongside the arithmetic in the back pipeline
    typedef struct packed {
        kind_t                 kind;
        logic                  absent;
        logic [RAW_W-1:0]      divisor;
        logic [1:0]            shift;
        logic [DIRECT_W-1:0]   direct;
    } tag_t;

    // Configuration register set
    typedef struct packed {
        logic [1:0] chip_type;
        logic [1:0] fan1_code;
        logic [1:0] fan2_code;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/hmrc_front.sv
// Front end: accepts items, classifies the channel and resolves gains and divisors.
`default_nettype none

module hmrc_front
    import hmrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [CMD_W-1:0]   cmd,
    input  wire logic [RAW_W-1:0]   raw,
    input  wire logic [RAW_W-1:0]   fraction_byte,
    input  wire logic               q_full,
    output logic                    q_push,
    output op_t                     q_data
);

    op_t  op_reg;
    op_t  op_next;
    logic op_valid_reg;
    logic op_valid_next;
    logic accept;

    // Hold the input while the classified item cannot enter the queue
    assign in_stall = op_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = op_valid_reg && !q_full;
    assign q_data   = op_reg;

    // Classify the channel
    always_comb
    begin
        op_next        = '0;
        op_next.kind   = KIND_DIRECT;
        op_next.raw    = raw;
        op_next.gain   = GAIN_UNIT;
        op_next.offset = OFFS_NONE;
        op_next.shift  = FAN3_SHIFT;
        case (cmd)
            CMD_CORE0, CMD_CORE1, CMD_3V3:
            begin
                op_next.kind = KIND_VOLT;
            end
            CMD_P5:
            begin
                op_next.kind = KIND_VOLT;
                op_next.gain = GAIN_P5;
            end
            CMD_P12:
            begin
                op_next.kind = KIND_VOLT;
                op_next.gain = (cfg.chip_type inside {CHIP_A, CHIP_B}) ? GAIN_4V00 : GAIN_3V80;
            end
            CMD_N12:
            begin
                op_next.kind = KIND_VOLT;
                case (cfg.chip_type)
                    CHIP_A, CHIP_B:
                    begin
                        op_next.gain   = GAIN_4V00;
                        op_next.negate = 1'b1;
                    end
                    CHIP_C:
                    begin
                        op_next.gain   = GAIN_3V47;
                        op_next.negate = 1'b1;
                    end
                    default:
                    begin
                        op_next.gain   = GAIN_D_N12;
                        op_next.offset = OFFS_D_N12;
                    end
                endcase
            end
            CMD_N5:
            begin
                op_next.kind = KIND_VOLT;
                case (cfg.chip_type)
                    CHIP_A:
                    begin
                        op_next.gain   = GAIN_1V667;
                        op_next.negate = 1'b1;
                    end
                    CHIP_B, CHIP_C:
                    begin
                        op_next.gain   = GAIN_1V50;
                        op_next.negate = 1'b1;
                    end
                    default:
                    begin
                        op_next.gain   = GAIN_D_N5;
                        op_next.offset = OFFS_D_N5;
                    end
                endcase
            end
            CMD_TEMP_LOCAL:
            begin
                op_next.direct = DIRECT_W'(raw) * TEMP_SCALE;
            end
            CMD_TEMP_R1, CMD_TEMP_R2:
            begin
                // Unconnected remote sensor reads above the valid range
                if (raw > REMOTE_MAX)
                begin
                    op_next.absent = 1'b1;
                end
                else
                begin
                    op_next.direct = DIRECT_W'(raw) * TEMP_SCALE
                                   + ((fraction_byte == FRAC_HALF) ? TEMP_HALF : '0);
                end
            end
            CMD_FAN1, CMD_FAN2, CMD_FAN3:
            begin
                if (raw == FAN_NONE || raw == FAN_STUCK)
                begin
                    op_next.absent = 1'b1;
                end
                else
                begin
                    op_next.kind = KIND_FAN;
                end
                case (cmd)
                    CMD_FAN1: op_next.shift = cfg.fan1_code;
                    CMD_FAN2: op_next.shift = cfg.fan2_code;
                    default:  op_next.shift = FAN3_SHIFT;
                endcase
            end
            default:
            begin
                op_next.kind = KIND_DIRECT;
            end
        endcase
    end

    // Track whether the classified item is still waiting
    always_comb
    begin
        op_valid_next = op_valid_reg;
        if (accept)
        begin
            op_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            op_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    // Capture the classified item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hmrc_queue.sv
// Short queue of classified items between front and back.
`default_nettype none

module hmrc_queue
    import hmrc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire op_t    push_data,
    output logic        full,
    input  wire logic   pop,
    output op_t         pop_data,
    output logic        empty
);

    op_t                    entry_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Adjust the fill count
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hmrc_back.sv
// Back end: voltage scaling with rounding, pipelined fan divider, output register.
`default_nettype none

module hmrc_back
    import hmrc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  wire op_t                    q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [VALUE_W-1:0]   value,
    output logic                        absent
);

    localparam int VOLT_STAGE = 4;

    logic                           en;
    logic [DIV_STAGES:0]            vld_reg;

    // Stage 0
    op_t                            op0_reg;

    // Divider stages 1 .. DIV_STAGES
    tag_t                           tag_reg  [1:DIV_STAGES];
    logic [RAW_W-1:0]               rem_reg  [1:DIV_STAGES];
    logic [DIV_W-1:0]               quot_reg [1:DIV_STAGES];

    // Voltage stages
    logic [PROD_W-1:0]              prod1_reg;
    logic [PROD_W-1:0]              prod1_next;
    logic [OFFS_W-1:0]              offset1_reg;
    logic                           negate1_reg;
    logic                           sign2_reg;
    logic                           sign2_next;
    logic [PROD_W-1:0]              mag2_reg;
    logic [PROD_W-1:0]              mag2_next;
    logic signed [PROD_W+1:0]       diff2;
    logic signed [PROD_W+1:0]       signed2;
    logic [PROD_W+1:0]              abs2;
    logic [PROD_W+RECIP_W-1:0]      scaled3;
    logic                           sign3_reg;
    logic [VOLT_Q_W-1:0]            q3_reg;
    logic [VOLT_Q_W-1:0]            q3_next;
    logic signed [VALUE_W-1:0]      volt_reg [VOLT_STAGE:DIV_STAGES];
    logic signed [VALUE_W-1:0]      volt4_next;

    // Output
    logic                           out_valid_reg;
    logic signed [VALUE_W-1:0]      value_reg;
    logic signed [VALUE_W-1:0]      value_next;
    logic                           absent_reg;
    logic [DIV_W-1:0]               rpm_last;

    function automatic logic [RAW_W+DIV_BPS-1:0] div_step(
        input logic [RAW_W-1:0]   rem_in,
        input logic [DIV_BPS-1:0] bits_in,
        input logic [RAW_W-1:0]   dvsr
    );
        logic [RAW_W:0]       part;
        logic [RAW_W-1:0]     rem_cur;
        logic [DIV_BPS-1:0]   qbits;
        rem_cur = rem_in;
        qbits   = '0;
        for (int i = DIV_BPS - 1; i >= 0; i--)
        begin
            part = {rem_cur, bits_in[i]};
            if (part >= {1'b0, dvsr})
            begin
                part     = part - {1'b0, dvsr};
                qbits[i] = 1'b1;
            end
            rem_cur = part[RAW_W-1:0];
        end
        return {rem_cur, qbits};
    endfunction

    // Advance the whole pipeline whenever the output register can take an item
    assign en        = !out_valid_reg || !out_stall;
    assign q_pop     = en && !q_empty;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign absent    = absent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DIV_STAGES-1:0], q_pop};
            out_valid_reg <= vld_reg[DIV_STAGES];
        end
    end

    // Load stage 0 from the queue
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg <= q_data;
        end
    end

    // Divider stages: a few quotient bits of the fixed dividend per stage
    for (genvar d = 1; d <= DIV_STAGES; d++)
    begin : g_div
        logic [RAW_W+DIV_BPS-1:0] step;
        if (d == 1)
        begin : g_first
            assign step = div_step('0, FAN_CONST[DIV_W-1 -: DIV_BPS], op0_reg.raw);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[d]  <= '{kind: op0_reg.kind, absent: op0_reg.absent,
                                     divisor: op0_reg.raw, shift: op0_reg.shift,
                                     direct: op0_reg.direct};
                    rem_reg[d]  <= step[RAW_W+DIV_BPS-1:DIV_BPS];
                    quot_reg[d] <= DIV_W'(step[DIV_BPS-1:0]);
                end
            end
        end
        else
        begin : g_rest
            assign step = div_step(rem_reg[d-1],
                                   FAN_CONST[DIV_W-1-(d-1)*DIV_BPS -: DIV_BPS],
                                   tag_reg[d-1].divisor);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[d]  <= tag_reg[d-1];
                    rem_reg[d]  <= step[RAW_W+DIV_BPS-1:DIV_BPS];
                    quot_reg[d] <= {quot_reg[d-1][DIV_W-DIV_BPS-1:0], step[DIV_BPS-1:0]};
                end
            end
        end
    end

    // Voltage: raw times 16 mV times gain
    assign prod1_next = PROD_W'({op0_reg.raw, 4'b0000}) * PROD_W'(op0_reg.gain);

    // Voltage: subtract offset, apply sign, add half for rounding
    always_comb
    begin
        diff2      = $signed({2'b00, prod1_reg}) - $signed({3'b000, offset1_reg});
        signed2    = negate1_reg ? -diff2 : diff2;
        sign2_next = signed2[PROD_W+1];
        abs2       = sign2_next ? $unsigned(-signed2) : $unsigned(signed2);
        mag2_next  = abs2[PROD_W-1:0] + ROUND_HALF;
    end

    // Voltage: divide by 1000 through the reciprocal
    assign scaled3 = (PROD_W+RECIP_W)'(mag2_reg) * (PROD_W+RECIP_W)'(RECIP_K);
    assign q3_next = scaled3[RECIP_SHIFT +: VOLT_Q_W];

    // Voltage: restore the sign
    assign volt4_next = sign3_reg ? -$signed(VALUE_W'(q3_reg)) : $signed(VALUE_W'(q3_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg          <= prod1_next;
            offset1_reg        <= op0_reg.offset;
            negate1_reg        <= op0_reg.negate;
            sign2_reg          <= sign2_next;
            mag2_reg           <= mag2_next;
            sign3_reg          <= sign2_reg;
            q3_reg             <= q3_next;
            volt_reg[VOLT_STAGE] <= volt4_next;
        end
    end

    // Delay the voltage to line up with the divider
    for (genvar v = VOLT_STAGE + 1; v <= DIV_STAGES; v++)
    begin : g_vdly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                volt_reg[v] <= volt_reg[v-1];
            end
        end
    end

    // Select the result for the output register
    assign rpm_last = quot_reg[DIV_STAGES] >> tag_reg[DIV_STAGES].shift;

    always_comb
    begin
        case (tag_reg[DIV_STAGES].kind)
            KIND_VOLT:   value_next = volt_reg[DIV_STAGES];
            KIND_FAN:    value_next = $signed(VALUE_W'(rpm_last));
            KIND_DIRECT: value_next = $signed(VALUE_W'(tag_reg[DIV_STAGES].direct));
            default:     value_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg  <= value_next;
            absent_reg <= tag_reg[DIV_STAGES].absent;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hw_monitor_reading_convert.sv
// Top level of the monitor reading converter: register file, front, queue, back.
//
//  Port group   Handshake              Payload
//  ----------   --------------------   ---------------------------------
//  in           in_valid / in_stall    cmd, raw, fraction_byte
//  out          out_valid / out_stall  value, absent
//  cfg          cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per cycle sustained while out_stall is low. With no stalls an item
//  passes the front register, queue, load stage, seven divider stages of
//  three quotient bits each, then the output register, where out_valid rises.
//  Reset clears all valid state and loads chip_type 2 and both fan codes 1.
//  A stalled output freezes the back pipeline; the queue then fills and the
//  input stalls. cfg_ready is always high.
`default_nettype none

module hw_monitor_reading_convert
    import hmrc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [CMD_W-1:0]       cmd,
    input  wire logic [RAW_W-1:0]       raw,
    input  wire logic [RAW_W-1:0]       fraction_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [VALUE_W-1:0]   value,
    output logic                        absent,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    op_t  q_push_data;
    op_t  q_pop_data;

    assign cfg_ready = 1'b1;

    // Write configuration registers; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{chip_type: CHIP_C, fan1_code: 2'd1, fan2_code: 2'd1};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CHIP_TYPE: cfg_reg.chip_type <= cfg_data;
                REG_FAN1_DIV:  cfg_reg.fan1_code <= cfg_data;
                REG_FAN2_DIV:  cfg_reg.fan2_code <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    hmrc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .raw           (raw),
        .fraction_byte (fraction_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    hmrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    hmrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .absent    (absent)
    );

endmodule

`default_nettype wire
